/* rtl/pfx_pkg.sv */
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared constants for the postfix evaluator: word width, symbol codes and
// result status codes.
// ----------------------------------------------------------------------------
package pfx_pkg;

    localparam int WORD_W = 32;

    // ASCII symbol codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;
    localparam logic [2:0] ST_SKIP    = 3'd5;

endpackage

/* rtl/pfx_div.sv */
// ----------------------------------------------------------------------------
// pfx_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Divisor must be non-zero. Quotient is valid while done is high.
// ----------------------------------------------------------------------------
module pfx_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfx_pkg::WORD_W-1:0]  dividend,
    input  logic [pfx_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [pfx_pkg::WORD_W-1:0]  quotient
);

    localparam int W  = pfx_pkg::WORD_W;
    localparam int SW = $clog2(W);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           neg_reg, neg_next;
    logic [W-1:0]   dq_reg, dq_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   dvs_reg, dvs_next;
    logic [W:0]     trial;

    assign trial = {rem_reg, dq_reg[W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            dq_next   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            dvs_next  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                dq_next  = {dq_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], dq_reg[W-1]};
                dq_next  = {dq_reg[W-2:0], 1'b0};
            end
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dq_reg + W'(1)) : dq_reg;

endmodule

/* rtl/postfix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix (RPN) evaluator on a 32-bit operand stack held in a synchronous
// single-write, single-read memory, with the top entry mirrored in a register.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------
//  input   | in_valid  / in_stall      | symbol[7:0], last_symbol
//  output  | out_valid / out_stall     | value[31:0], status[2:0], final_res
//
// One item at a time. A digit or skipped/invalid symbol goes from idle to the
// output state; + - and * (and a divide by zero) pass through execute and
// write-back first, and a final pop that must reload the new top adds a refill
// state. Division runs through an iterative divider in a divide-wait state.
// Reset empties the stack and clears skipping; stack memory is not cleared.
// Input is taken whenever the sequencer is idle, even while a result waits
// on a stalled output; the sequencer only holds if the output register is
// still occupied when its next result is ready.
//
module postfix_expression_evaluator
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         symbol,
    input  logic               last_symbol,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    output logic               final_res
);

    localparam int W  = pfx_pkg::WORD_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // one-hot sequencer
    typedef enum logic [5:0]
    {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_DIV    = 6'b000100,
        S_WB     = 6'b001000,
        S_REFILL = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           skip_reg, skip_next;
    logic [W-1:0]   top_reg, top_next;
    logic [7:0]     sym_reg, sym_next;
    logic           last_reg, last_next;
    logic [W-1:0]   opb_reg, opb_next;
    logic [W-1:0]   res_reg, res_next;
    logic [W-1:0]   pval_reg, pval_next;     // pending result
    logic [2:0]     pst_reg, pst_next;
    logic           pfin_reg, pfin_next;
    logic           ov_reg, ov_next;         // output register
    logic [W-1:0]   oval_reg, oval_next;
    logic [2:0]     ost_reg, ost_next;
    logic           ofin_reg, ofin_next;

    // stack memory
    logic [W-1:0]   stack_mem [STACK_DEPTH];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [W-1:0]   mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [W-1:0]   rdata_reg;

    // divider
    logic           div_start;
    logic           div_done;
    logic [W-1:0]   div_q;
    logic [W-1:0]   opa;
    logic [W-1:0]   prod;

    pfx_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa),
        .divisor  (opb_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand a comes from memory when at least two entries are stacked
    assign opa  = (count_reg >= CW'(2)) ? rdata_reg : '1;
    assign prod = opa * opb_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= stack_mem[mem_raddr];
        end
    end

    always_comb
    begin
        logic [W-1:0]  digit;
        logic [W-1:0]  top_after;
        logic [CW-1:0] cnt_after;
        logic [CW-1:0] cnt_m1;
        logic [CW-1:0] cnt_m2;

        state_next = state_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        top_next   = top_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        opb_next   = opb_reg;
        res_next   = res_reg;
        pval_next  = pval_reg;
        pst_next   = pst_reg;
        pfin_next  = pfin_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        ofin_next  = ofin_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        div_start  = 1'b0;
        digit      = '0;
        top_after  = top_reg;
        cnt_after  = count_reg;
        cnt_m1     = '0;
        cnt_m2     = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next  = symbol;
                    last_next = last_symbol;
                    pfin_next = last_symbol;
                    if (skip_reg)
                    begin
                        // rest of a failed expression: report top (all ones if empty), stack unchanged
                        pval_next = (count_reg == '0) ? '1 : top_reg;
                        pst_next  = pfx_pkg::ST_SKIP;
                        pfin_next = 1'b0;
                        if (last_symbol)
                        begin
                            skip_next = 1'b0;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        case (symbol) inside
                            [pfx_pkg::CH_ZERO : pfx_pkg::CH_NINE]:
                            begin
                                digit = W'(symbol - pfx_pkg::CH_ZERO);
                                if (count_reg < DEPTH_C)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = count_reg[AW-1:0];
                                    mem_wdata = digit;
                                    top_after = digit;
                                    cnt_after = count_reg + CW'(1);
                                    pst_next  = pfx_pkg::ST_OK;
                                end
                                else
                                begin
                                    pst_next  = pfx_pkg::ST_FULL;
                                end
                                top_next  = top_after;
                                pval_next = top_after;
                                if (last_symbol)
                                begin
                                    // final pop: reload new top from memory
                                    cnt_m1     = cnt_after - CW'(1);
                                    cnt_m2     = cnt_after - CW'(2);
                                    count_next = cnt_m1;
                                    if (cnt_after > CW'(1))
                                    begin
                                        mem_re     = 1'b1;
                                        mem_raddr  = cnt_m2[AW-1:0];
                                        state_next = S_REFILL;
                                    end
                                    else
                                    begin
                                        state_next = S_OUT;
                                    end
                                end
                                else
                                begin
                                    count_next = cnt_after;
                                    state_next = S_OUT;
                                end
                            end
                            pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
                            pfx_pkg::CH_MUL, pfx_pkg::CH_DIV:
                            begin
                                opb_next = (count_reg == '0) ? '1 : top_reg;
                                cnt_m2   = count_reg - CW'(2);
                                if (count_reg >= CW'(2))
                                begin
                                    mem_re    = 1'b1;
                                    mem_raddr = cnt_m2[AW-1:0];
                                end
                                state_next = S_EXEC;
                            end
                            default:
                            begin
                                pval_next  = '1;
                                pst_next   = pfx_pkg::ST_INVALID;
                                pfin_next  = 1'b1;
                                skip_next  = !last_symbol;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                end
            end

            S_EXEC:
            begin
                pst_next   = (count_reg < CW'(2)) ? pfx_pkg::ST_EMPTY : pfx_pkg::ST_OK;
                state_next = S_WB;
                case (sym_reg)
                    pfx_pkg::CH_PLUS:  res_next = opa + opb_reg;
                    pfx_pkg::CH_MINUS: res_next = opa - opb_reg;
                    pfx_pkg::CH_MUL:   res_next = prod;
                    pfx_pkg::CH_DIV:
                    begin
                        if (opb_reg == '0)
                        begin
                            res_next = '0;
                            if (count_reg >= CW'(2))
                            begin
                                pst_next = pfx_pkg::ST_DIVZERO;
                            end
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: res_next = res_reg;
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                // two pops then one push
                cnt_after = (count_reg >= CW'(2)) ? (count_reg - CW'(1)) : CW'(1);
                cnt_m1    = cnt_after - CW'(1);
                cnt_m2    = cnt_after - CW'(2);
                mem_we    = 1'b1;
                mem_waddr = cnt_m1[AW-1:0];
                mem_wdata = res_reg;
                top_next  = res_reg;
                pval_next = res_reg;
                if (last_reg)
                begin
                    count_next = cnt_m1;
                    if (cnt_after > CW'(1))
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = cnt_m2[AW-1:0];
                        state_next = S_REFILL;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    count_next = cnt_after;
                    state_next = S_OUT;
                end
            end

            S_REFILL:
            begin
                top_next   = rdata_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oval_next  = pval_reg;
                    ost_next   = pst_reg;
                    ofin_next  = pfin_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            skip_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        opb_reg  <= opb_next;
        res_reg  <= res_next;
        pval_reg <= pval_next;
        pst_reg  <= pst_next;
        pfin_reg <= pfin_next;
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
        ofin_reg <= ofin_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign value     = oval_reg;
    assign status    = ost_reg;
    assign final_res = ofin_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("stack count beyond depth");

    a_invalid_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == pfx_pkg::ST_INVALID) |-> final_res && (value == -32'sd1))
        else $error("invalid operator result malformed");

    a_skip_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == pfx_pkg::ST_SKIP) |-> !final_res)
        else $error("skipped symbol marked final");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide wait");

endmodule
